// File: hw/rtl/matrix2x2_alu_top_macros.svh
// ---------------------------------------------------------------------------
// matrix2x2_alu_top_macros.svh
// Assertion macros used by the matrix unit top level.
// ---------------------------------------------------------------------------
`ifndef MATRIX2X2_ALU_TOP_MACROS_SVH
`define MATRIX2X2_ALU_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MTX_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("matrix unit assertion failed");

// next-cycle implication
`define MTX_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("matrix unit assertion failed");

`else

`define MTX_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define MTX_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: hw/rtl/mtx_pkg.sv
// ---------------------------------------------------------------------------
// mtx_pkg
// Types, opcodes, pipeline stage numbers and saturation helper for the
// 2x2 Q16.16 matrix unit.
// ---------------------------------------------------------------------------
`default_nettype none

package mtx_pkg;

   // opcodes
   typedef enum logic [3:0] {
      OP_ADD    = 4'd0,
      OP_SUB    = 4'd1,
      OP_MUL    = 4'd2,
      OP_MATDIV = 4'd3,
      OP_SADD   = 4'd4,
      OP_SSUB   = 4'd5,
      OP_SMUL   = 4'd6,
      OP_SDIV   = 4'd7,
      OP_DET    = 4'd8,
      OP_TRANS  = 4'd9,
      OP_ADJ    = 4'd10,
      OP_INV    = 4'd11,
      OP_EQUAL  = 4'd12
   } mtx_op_type;

   typedef logic signed [31:0] elem_type;   // Q16.16 element
   typedef logic signed [48:0] acc_type;    // rounded sum before clipping
   typedef logic signed [64:0] det_type;    // exact Q32.32 determinant

   // element order: r0c0, r1c0, r0c1, r1c1
   typedef struct packed {
      mtx_op_type     op;
      elem_type [3:0] a;
      elem_type [3:0] b;
      elem_type       s;
   } mtx_item_type;

   // divider operand selection handed to each lane
   typedef struct packed {
      logic                inv_sel;   // 1: adjugate / det, 0: element / scalar
      logic signed [32:0]  adj;
      elem_type            a;
      elem_type            s;
   } div_opnd_type;

   typedef struct packed {
      elem_type [3:0] r;
      elem_type       sc;
      logic           eq;
      logic           dz;
      logic           sat;
   } mtx_result_type;

   // pipeline stage numbers (stage 0 is the input register)
   localparam int DIV_STEPS = 33;                    // quotient bits 32..0
   localparam int ST_DET    = 2;
   localparam int ST_OPND   = 3;
   localparam int ST_QUOT   = ST_OPND + DIV_STEPS + 2;
   localparam int ST_SUM    = ST_QUOT + 2;
   localparam int ST_OUT    = ST_SUM + 1;

   localparam int FRAC_BITS = 16;

   localparam acc_type ELEM_MAX = 49'sd2147483647;
   localparam acc_type ELEM_MIN = -49'sd2147483648;

   // sign extension into the accumulator width
   function automatic acc_type ext_acc(input elem_type v);
      return acc_type'(v);
   endfunction

   // clip to 32 bits; returns {clipped, value}
   function automatic logic [32:0] clip(input acc_type v);
      logic [32:0] res;
      if (v > ELEM_MAX) begin
         res = {1'b1, 32'h7FFF_FFFF};
      end else if (v < ELEM_MIN) begin
         res = {1'b1, 32'h8000_0000};
      end else begin
         res = {1'b0, v[31:0]};
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mtx_det.sv
// ---------------------------------------------------------------------------
// mtx_det
// Exact 2x2 determinant in Q32.32 plus its Q16.16 rounding and zero test.
// ---------------------------------------------------------------------------
`default_nettype none

module mtx_det import mtx_pkg::*; (
   input  wire logic           clock,
   input  wire logic           advance,
   input  wire elem_type [3:0] m,         // stage 0
   output det_type             det,       // stage 2
   output acc_type             det_rnd,   // stage 3
   output logic                det_zero   // stage 3
);

   logic signed [63:0] prod_a_ff, prod_b_ff;
   det_type            det_ff;
   acc_type            rnd_ff;
   logic               zero_ff;
   det_type            rnd_sum;

   // round half up, floor shift keeps the upper bits
   assign rnd_sum = det_ff + 65'sd32768;

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_a_ff <= $signed(m[0]) * $signed(m[3]);
         prod_b_ff <= $signed(m[2]) * $signed(m[1]);
         det_ff    <= det_type'(prod_a_ff) - det_type'(prod_b_ff);
         rnd_ff    <= rnd_sum[64:FRAC_BITS];
         zero_ff   <= (det_ff == '0);
      end
   end

   assign det      = det_ff;
   assign det_rnd  = rnd_ff;
   assign det_zero = zero_ff;

endmodule

`default_nettype wire

// File: hw/rtl/mtx_lane.sv
// ---------------------------------------------------------------------------
// mtx_lane
// One result element: pipelined restoring divider (scalar divide or inverse
// element), then a two-product multiply-accumulate with round half up.
// ---------------------------------------------------------------------------
`default_nettype none

module mtx_lane import mtx_pkg::*; (
   input  wire logic         clock,
   input  wire logic         advance,
   // stage 2
   input  wire div_opnd_type opnd,
   input  wire det_type      det,
   // stage 38
   input  wire elem_type     x0,
   input  wire elem_type     m0,
   input  wire elem_type     x1,
   input  wire elem_type     m1,
   output elem_type          quot,       // stage 38
   // stage 40
   output elem_type          quot_out,
   output logic              quot_sat,
   output acc_type           sum
);

   logic [31:0] adj_mag, a_mag, s_mag;
   logic [63:0] det_mag;
   logic [63:0] num_in, den_in;
   logic        neg_in;

   logic [63:0] num_ff, den_op_ff;
   logic        neg_op_ff;

   logic [63:0]          rem_ff [DIV_STEPS+1];
   logic [63:0]          den_ff [DIV_STEPS+1];
   logic                 neg_ff [DIV_STEPS+1];
   logic                 ov_ff  [DIV_STEPS+1];
   logic [DIV_STEPS-1:0] q_ff   [DIV_STEPS+1];
   logic                 fit    [DIV_STEPS+1];

   logic [DIV_STEPS-1:0] q_fin;
   elem_type             quot_in;
   logic                 qsat_in;

   elem_type             quot_ff, quot_d1_ff, quot_d2_ff;
   logic                 qsat_ff, qsat_d1_ff, qsat_d2_ff;
   logic signed [63:0]   prod0_ff, prod1_ff;
   acc_type              sum_ff;
   det_type              tot;

   // divider operands: magnitudes with half the divisor added for rounding
   always_comb begin
      adj_mag = opnd.adj[32] ? 32'(-opnd.adj) : opnd.adj[31:0];
      det_mag = det[64] ? 64'(-det) : det[63:0];
      a_mag   = opnd.a[31] ? (~opnd.a + 32'd1) : opnd.a;
      s_mag   = opnd.s[31] ? (~opnd.s + 32'd1) : opnd.s;
      if (opnd.inv_sel) begin
         num_in = {adj_mag, 32'd0} + {1'b0, det_mag[63:1]};
         den_in = det_mag;
         neg_in = opnd.adj[32] != det[64];
      end else begin
         num_in = {16'd0, a_mag, 16'd0} + {33'd0, s_mag[31:1]};
         den_in = {32'd0, s_mag};
         neg_in = opnd.a[31] != opnd.s[31];
      end
   end

   // trial compare for each quotient bit, most significant first
   always_comb begin
      fit[0] = 1'b0;
      for (int j = 1; j <= DIV_STEPS; j++) begin
         fit[j] = (rem_ff[j-1] >> (DIV_STEPS - j)) >= den_ff[j-1];
      end
   end

   // operand, overflow check and divide step registers
   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff    <= num_in;
         den_op_ff <= den_in;
         neg_op_ff <= neg_in;
         rem_ff[0] <= num_ff;
         den_ff[0] <= den_op_ff;
         neg_ff[0] <= neg_op_ff;
         ov_ff[0]  <= (num_ff >> DIV_STEPS) >= den_op_ff;
         q_ff[0]   <= '0;
         for (int j = 1; j <= DIV_STEPS; j++) begin
            rem_ff[j] <= fit[j] ? rem_ff[j-1] - (den_ff[j-1] << (DIV_STEPS - j))
                                : rem_ff[j-1];
            den_ff[j] <= den_ff[j-1];
            neg_ff[j] <= neg_ff[j-1];
            ov_ff[j]  <= ov_ff[j-1];
            q_ff[j]   <= {q_ff[j-1][DIV_STEPS-2:0], fit[j]};
         end
      end
   end

   // apply sign and clip the quotient
   always_comb begin
      q_fin = q_ff[DIV_STEPS];
      if (!neg_ff[DIV_STEPS]) begin
         qsat_in = ov_ff[DIV_STEPS] || (q_fin > 33'h0_7FFF_FFFF);
         quot_in = qsat_in ? 32'sh7FFF_FFFF : q_fin[31:0];
      end else begin
         qsat_in = ov_ff[DIV_STEPS] || (q_fin > 33'h0_8000_0000);
         quot_in = qsat_in ? 32'sh8000_0000 : (32'd0 - q_fin[31:0]);
      end
   end

   // two products, then the rounded sum
   assign tot = det_type'(prod0_ff) + det_type'(prod1_ff) + 65'sd32768;

   always_ff @(posedge clock) begin
      if (advance) begin
         quot_ff    <= quot_in;
         qsat_ff    <= qsat_in;
         prod0_ff   <= x0 * m0;
         prod1_ff   <= x1 * m1;
         quot_d1_ff <= quot_ff;
         qsat_d1_ff <= qsat_ff;
         sum_ff     <= tot[64:FRAC_BITS];
         quot_d2_ff <= quot_d1_ff;
         qsat_d2_ff <= qsat_d1_ff;
      end
   end

   assign quot     = quot_ff;
   assign quot_out = quot_d2_ff;
   assign quot_sat = qsat_d2_ff;
   assign sum      = sum_ff;

endmodule

`default_nettype wire

// File: hw/rtl/mtx_merge.sv
// ---------------------------------------------------------------------------
// mtx_merge
// Picks each element per opcode from the request operands or the lane results,
// clips, and gathers the flags into the registered response.
// ---------------------------------------------------------------------------
`default_nettype none

module mtx_merge import mtx_pkg::*; (
   input  wire logic           clock,
   input  wire logic           advance,
   input  wire mtx_item_type   item,
   input  wire acc_type        sum [4],
   input  wire elem_type       quot [4],
   input  wire logic           quot_sat [4],
   input  wire acc_type        det_rnd,
   input  wire logic           det_zero,
   output mtx_result_type      result
);

   logic [32:0]    add_c [4];
   logic [32:0]    sub_c [4];
   logic [32:0]    sadd_c [4];
   logic [32:0]    ssub_c [4];
   logic [32:0]    neg_c [4];
   logic [32:0]    sum_c [4];
   logic [32:0]    det_c;
   elem_type [3:0] r_val;
   logic [3:0]     r_sat;
   mtx_result_type res_in;
   mtx_result_type res_ff;

   // candidate values for every element
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         add_c[i]  = clip(ext_acc(item.a[i]) + ext_acc(item.b[i]));
         sub_c[i]  = clip(ext_acc(item.a[i]) - ext_acc(item.b[i]));
         sadd_c[i] = clip(ext_acc(item.a[i]) + ext_acc(item.s));
         ssub_c[i] = clip(ext_acc(item.a[i]) - ext_acc(item.s));
         neg_c[i]  = clip(-ext_acc(item.a[i]));
         sum_c[i]  = clip(sum[i]);
      end
      det_c = clip(det_rnd);
   end

   // opcode select
   always_comb begin
      r_val  = '0;
      r_sat  = '0;
      res_in = '0;
      case (item.op)
         OP_ADD: begin
            for (int i = 0; i < 4; i++) {r_sat[i], r_val[i]} = add_c[i];
         end
         OP_SUB: begin
            for (int i = 0; i < 4; i++) {r_sat[i], r_val[i]} = sub_c[i];
         end
         OP_MUL, OP_SMUL: begin
            for (int i = 0; i < 4; i++) {r_sat[i], r_val[i]} = sum_c[i];
         end
         OP_MATDIV: begin
            // inverse saturation counts only when B was invertible
            for (int i = 0; i < 4; i++) begin
               r_val[i] = sum_c[i][31:0];
               r_sat[i] = sum_c[i][32] | (!det_zero & quot_sat[i]);
            end
            res_in.dz = det_zero;
         end
         OP_SADD: begin
            for (int i = 0; i < 4; i++) {r_sat[i], r_val[i]} = sadd_c[i];
         end
         OP_SSUB: begin
            for (int i = 0; i < 4; i++) {r_sat[i], r_val[i]} = ssub_c[i];
         end
         OP_SDIV: begin
            if (item.s == '0) begin
               r_val     = item.a;
               res_in.dz = 1'b1;
            end else begin
               for (int i = 0; i < 4; i++) begin
                  r_val[i] = quot[i];
                  r_sat[i] = quot_sat[i];
               end
            end
         end
         OP_DET: begin
            res_in.sc  = det_c[31:0];
            r_sat[0]   = det_c[32];
         end
         OP_TRANS: begin
            r_val[0] = item.a[0];
            r_val[1] = item.a[2];
            r_val[2] = item.a[1];
            r_val[3] = item.a[3];
         end
         OP_ADJ: begin
            r_val[0]             = item.a[3];
            {r_sat[1], r_val[1]} = neg_c[1];
            {r_sat[2], r_val[2]} = neg_c[2];
            r_val[3]             = item.a[0];
         end
         OP_INV: begin
            if (det_zero) begin
               r_val     = item.a;
               res_in.dz = 1'b1;
            end else begin
               for (int i = 0; i < 4; i++) begin
                  r_val[i] = quot[i];
                  r_sat[i] = quot_sat[i];
               end
            end
         end
         OP_EQUAL: begin
            res_in.eq = (item.a == item.b);
         end
         default: begin
            r_val = '0;
         end
      endcase
      res_in.r   = r_val;
      res_in.sat = |r_sat;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

`default_nettype wire

// File: hw/rtl/matrix2x2_alu_top.sv
// ---------------------------------------------------------------------------
// matrix2x2_alu_top
// Q16.16 2x2 matrix arithmetic unit with saturating results.
// ---------------------------------------------------------------------------
// The unit takes one request per clock while req_ready is high and returns
// responses in request order. The depth comes from the four divider lanes,
// which resolve one quotient bit per stage over 33 stages (scalar divide and
// inverse, and the inverse of B feeding the multiply for A times inv(B)),
// followed by the product and rounding stages. The pipeline advances as a
// whole: while a response waits at the output with rsp_ready low, req_ready
// is low and all stages hold.
`default_nettype none
`include "matrix2x2_alu_top_macros.svh"

module matrix2x2_alu_top import mtx_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [3:0]  req_operation,
   input  wire logic [31:0] req_a_row0_col0,
   input  wire logic [31:0] req_a_row1_col0,
   input  wire logic [31:0] req_a_row0_col1,
   input  wire logic [31:0] req_a_row1_col1,
   input  wire logic [31:0] req_b_row0_col0,
   input  wire logic [31:0] req_b_row1_col0,
   input  wire logic [31:0] req_b_row0_col1,
   input  wire logic [31:0] req_b_row1_col1,
   input  wire logic [31:0] req_scalar_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_r_row0_col0,
   output logic [31:0]      rsp_r_row1_col0,
   output logic [31:0]      rsp_r_row0_col1,
   output logic [31:0]      rsp_r_row1_col1,
   output logic [31:0]      rsp_scalar_out,
   output logic             rsp_equal_flag,
   output logic             rsp_div_zero,
   output logic             rsp_saturated
);

   logic           advance;
   logic           vld_ff [ST_OUT+1];
   mtx_item_type   pl_ff  [ST_SUM+1];
   mtx_item_type   req_item;
   logic           dzr_ff [ST_OPND+1:ST_SUM];
   acc_type        drnd_ff [ST_OPND+1:ST_SUM];

   elem_type [3:0] det_m0, det_m2;
   det_type        det;
   acc_type        det_rnd;
   logic           det_zero;

   div_opnd_type   opnd [4];
   logic signed [32:0] adj [4];
   elem_type       quot [4];
   elem_type       quot_out [4];
   logic           quot_sat [4];
   acc_type        sum [4];
   elem_type       mul_x0 [4], mul_m0 [4], mul_x1 [4], mul_m1 [4];
   elem_type [3:0] rhs;
   mtx_item_type   item_q;
   mtx_result_type result;

   // whole pipeline moves unless a response is held
   assign advance   = !vld_ff[ST_OUT] || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      req_item.op   = mtx_op_type'(req_operation);
      req_item.a[0] = req_a_row0_col0;
      req_item.a[1] = req_a_row1_col0;
      req_item.a[2] = req_a_row0_col1;
      req_item.a[3] = req_a_row1_col1;
      req_item.b[0] = req_b_row0_col0;
      req_item.b[1] = req_b_row1_col0;
      req_item.b[2] = req_b_row0_col1;
      req_item.b[3] = req_b_row1_col1;
      req_item.s    = req_scalar_in;
   end

   // valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= ST_OUT; k++) vld_ff[k] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k <= ST_OUT; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // request delay line, determinant side results
   always_ff @(posedge clock) begin
      if (advance) begin
         pl_ff[0] <= req_item;
         for (int k = 1; k <= ST_SUM; k++) pl_ff[k] <= pl_ff[k-1];
         dzr_ff[ST_OPND+1]  <= det_zero;
         drnd_ff[ST_OPND+1] <= det_rnd;
         for (int k = ST_OPND + 2; k <= ST_SUM; k++) begin
            dzr_ff[k]  <= dzr_ff[k-1];
            drnd_ff[k] <= drnd_ff[k-1];
         end
      end
   end

   // determinant of B for A times inv(B), else of A
   assign det_m0 = (pl_ff[0].op == OP_MATDIV) ? pl_ff[0].b : pl_ff[0].a;
   assign det_m2 = (pl_ff[ST_DET].op == OP_MATDIV) ? pl_ff[ST_DET].b : pl_ff[ST_DET].a;

   mtx_det u_det (
      .clock    (clock),
      .advance  (advance),
      .m        (det_m0),
      .det      (det),
      .det_rnd  (det_rnd),
      .det_zero (det_zero)
   );

   // adjugate elements, exact in 33 bits
   assign adj[0] = 33'(det_m2[3]);
   assign adj[1] = -33'(det_m2[1]);
   assign adj[2] = -33'(det_m2[2]);
   assign adj[3] = 33'(det_m2[0]);

   // multiply operand: inverse of B when it exists, else B
   assign item_q = pl_ff[ST_QUOT];
   always_comb begin
      if (item_q.op == OP_MATDIV && !dzr_ff[ST_QUOT]) begin
         for (int i = 0; i < 4; i++) rhs[i] = quot[i];
      end else begin
         rhs = item_q.b;
      end
   end

   for (genvar i = 0; i < 4; i++) begin : g_lane
      always_comb begin
         opnd[i].inv_sel = (pl_ff[ST_DET].op == OP_MATDIV) ||
                           (pl_ff[ST_DET].op == OP_INV);
         opnd[i].adj     = adj[i];
         opnd[i].a       = pl_ff[ST_DET].a[i];
         opnd[i].s       = pl_ff[ST_DET].s;
         if (item_q.op == OP_SMUL) begin
            mul_x0[i] = item_q.a[i];
            mul_m0[i] = item_q.s;
            mul_x1[i] = '0;
            mul_m1[i] = '0;
         end else begin
            mul_x0[i] = item_q.a[i % 2];
            mul_m0[i] = rhs[2 * (i / 2)];
            mul_x1[i] = item_q.a[(i % 2) + 2];
            mul_m1[i] = rhs[2 * (i / 2) + 1];
         end
      end

      mtx_lane u_lane (
         .clock    (clock),
         .advance  (advance),
         .opnd     (opnd[i]),
         .det      (det),
         .x0       (mul_x0[i]),
         .m0       (mul_m0[i]),
         .x1       (mul_x1[i]),
         .m1       (mul_m1[i]),
         .quot     (quot[i]),
         .quot_out (quot_out[i]),
         .quot_sat (quot_sat[i]),
         .sum      (sum[i])
      );
   end

   mtx_merge u_merge (
      .clock    (clock),
      .advance  (advance),
      .item     (pl_ff[ST_SUM]),
      .sum      (sum),
      .quot     (quot_out),
      .quot_sat (quot_sat),
      .det_rnd  (drnd_ff[ST_SUM]),
      .det_zero (dzr_ff[ST_SUM]),
      .result   (result)
   );

   // response ports
   assign rsp_valid       = vld_ff[ST_OUT];
   assign rsp_r_row0_col0 = result.r[0];
   assign rsp_r_row1_col0 = result.r[1];
   assign rsp_r_row0_col1 = result.r[2];
   assign rsp_r_row1_col1 = result.r[3];
   assign rsp_scalar_out  = result.sc;
   assign rsp_equal_flag  = result.eq;
   assign rsp_div_zero    = result.dz;
   assign rsp_saturated   = result.sat;

   `MTX_ASSERT_IMPL(a_held_blocks_req, clock, reset, vld_ff[ST_OUT] && !rsp_ready, !req_ready)
   `MTX_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && req_ready, vld_ff[0])
   `MTX_ASSERT_IMPL(a_equal_clean, clock, reset, rsp_valid && rsp_equal_flag, !rsp_div_zero && !rsp_saturated && rsp_scalar_out == '0)

endmodule

`default_nettype wire
